FILE: sv/mpq_pkg.sv
// Package for the max priority queue core: op codes, record layout and FSM states.
// No dependencies; imported by mpq_ram, mpq_engine and the top level.
package mpq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int TAG_W        = 64;
   localparam int ROLL_W       = 16;
   localparam int SCORE_W      = 10;
   localparam int KEY_W        = SCORE_W + ROLL_W;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PEEK   = 2'd1,
      OP_POP    = 2'd2
   } op_type;

   // Key is score over inverted roll number, so a larger key has priority
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic      is_empty;
      logic      dropped_full;
      entry_type top;
   } resp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_LD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_TOP_RD,
      ST_TOP_WAIT,
      ST_EMPTY_RES
   } state_type;

   function automatic logic [KEY_W-1:0] make_key(logic [SCORE_W-1:0] score,
                                                 logic [ROLL_W-1:0]  roll);
      return {score, ~roll};
   endfunction

endpackage

FILE: sv/mpq_ram.sv
// Heap record store: one write port, two registered read ports.
// Depends on mpq_pkg for the record type.
module mpq_ram
   import mpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr_a,
   input  logic [IDX_W-1:0] rd_addr_b,
   output entry_type        rd_data_a,
   output entry_type        rd_data_b
);

   entry_type mem [CAPACITY];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   // Write one record
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read two records, hold the data when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: sv/mpq_engine.sv
// Heap sequencer: entry count, sift-up and sift-down over the record store.
// Depends on mpq_pkg; drives the ports of mpq_ram.
module mpq_engine
   import mpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         op,
   input  logic [TAG_W-1:0]   name_tag,
   input  logic [ROLL_W-1:0]  roll_number,
   input  logic [SCORE_W-1:0] score,
   output logic               ready,
   output logic               res_valid,
   output resp_type           res,
   input  logic               res_take,
   output logic               wr_en,
   output logic [IDX_W-1:0]   wr_addr,
   output entry_type          wr_data,
   output logic               rd_en,
   output logic [IDX_W-1:0]   rd_addr_a,
   output logic [IDX_W-1:0]   rd_addr_b,
   input  entry_type          rd_data_a,
   input  entry_type          rd_data_b
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   entry_type        item_ff, item_in;
   logic             dropped_ff, dropped_in;

   logic [IDX_W-1:0] parent_idx;
   logic [CNT_W:0]   left_idx;
   logic [CNT_W:0]   right_idx;
   logic             right_ok;
   logic             pick_right;
   entry_type        best;
   logic [IDX_W-1:0] best_idx;

   // Heap index arithmetic
   assign parent_idx = (idx_ff - 1'b1) >> 1;
   assign left_idx   = (CNT_W+1)'({idx_ff, 1'b1});
   assign right_idx  = left_idx + 1'b1;
   assign right_ok   = right_idx < {1'b0, count_ff};
   assign pick_right = right_ok && (rd_data_b.key > rd_data_a.key);
   assign best       = pick_right ? rd_data_b : rd_data_a;
   assign best_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      item_ff    <= item_in;
      dropped_ff <= dropped_in;
   end

   // Advance the sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      item_in    = item_ff;
      dropped_in = dropped_ff;
      ready      = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = item_ff;
      rd_en      = 1'b0;
      rd_addr_a  = '0;
      rd_addr_b  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               dropped_in = 1'b0;
               idx_in     = '0;
               unique case (op)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        dropped_in = 1'b1;
                        state_in   = ST_TOP_RD;
                     end else begin
                        item_in  = '{tag: name_tag, key: make_key(score, roll_number)};
                        idx_in   = count_ff[IDX_W-1:0];
                        count_in = count_ff + 1'b1;
                        state_in = ST_UP_RD;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        state_in = ST_EMPTY_RES;
                     end else begin
                        count_in = count_ff - 1'b1;
                        state_in = (count_ff == CNT_W'(1)) ? ST_EMPTY_RES : ST_POP_RD;
                     end
                  end
                  default: begin
                     state_in = (count_ff == '0) ? ST_EMPTY_RES : ST_TOP_RD;
                  end
               endcase
            end
         end

         // Sift up: move the hole toward the root
         ST_UP_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_TOP_RD;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = parent_idx;
               state_in  = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (item_ff.key > rd_data_a.key) begin
               wr_data  = rd_data_a;
               idx_in   = parent_idx;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_TOP_RD;
            end
         end

         // Pop: fetch the last record into the item register
         ST_POP_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = count_ff[IDX_W-1:0];
            state_in  = ST_POP_LD;
         end

         ST_POP_LD: begin
            item_in  = rd_data_a;
            state_in = ST_DN_RD;
         end

         // Sift down: move the hole toward the leaves
         ST_DN_RD: begin
            if (left_idx >= {1'b0, count_ff}) begin
               wr_en    = 1'b1;
               state_in = ST_TOP_RD;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = left_idx[IDX_W-1:0];
               rd_addr_b = right_idx[IDX_W-1:0];
               state_in  = ST_DN_CMP;
            end
         end

         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (best.key > item_ff.key) begin
               wr_data  = best;
               idx_in   = best_idx;
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_TOP_RD;
            end
         end

         // Report the root
         ST_TOP_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = '0;
            state_in  = ST_TOP_WAIT;
         end

         ST_TOP_WAIT: begin
            res_valid        = 1'b1;
            res.is_empty     = 1'b0;
            res.dropped_full = dropped_ff;
            res.top          = rd_data_a;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         // Empty queue: zero score and zero roll number in key form
         ST_EMPTY_RES: begin
            res_valid    = 1'b1;
            res.is_empty = 1'b1;
            res.top.key  = make_key('0, '0);
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/max_priority_queue_composite_key_core.sv
// Max priority queue core with a binary heap in a record store with registered reads.
// The engine handles one item at a time and takes no new item until its result loads into
// the result register, which then lets the next item in while the result waits to transfer.
// A sift moves the record one heap level per read and compare state pair.
// Reset clears the entry count and the control state; the record store is not cleared.
module max_priority_queue_composite_key_core
   import mpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [TAG_W-1:0]   req_name_tag,
   input  logic [ROLL_W-1:0]  req_roll_number,
   input  logic [SCORE_W-1:0] req_score,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_empty,
   output logic               rsp_dropped_full,
   output logic [TAG_W-1:0]   rsp_top_name_tag,
   output logic [ROLL_W-1:0]  rsp_top_roll_number,
   output logic [SCORE_W-1:0] rsp_top_score
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic             ready;
   logic             start;
   logic             res_valid;
   resp_type         res;
   logic             res_take;
   logic             out_free;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr_a;
   logic [IDX_W-1:0] rd_addr_b;
   entry_type        rd_data_a;
   entry_type        rd_data_b;
   logic             rsp_valid_ff, rsp_valid_in;
   resp_type         rsp_ff, rsp_in;

   assign req_stall = !ready;
   assign start     = req_valid && ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign res_take  = res_valid && out_free;

   mpq_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .op          (req_op),
      .name_tag    (req_name_tag),
      .roll_number (req_roll_number),
      .score       (req_score),
      .ready       (ready),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b)
   );

   mpq_ram #(
      .CAPACITY (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Load the result register, drop valid once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_empty        = rsp_ff.is_empty;
   assign rsp_dropped_full    = rsp_ff.dropped_full;
   assign rsp_top_name_tag    = rsp_ff.top.tag;
   assign rsp_top_roll_number = ~rsp_ff.top.key[ROLL_W-1:0];
   assign rsp_top_score       = rsp_ff.top.key[KEY_W-1:ROLL_W];

   // One item at a time: the engine is busy right after a transfer in
   a_busy_after_start : assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("engine took a second item back to back");

   // A refused insert only happens on a full queue
   a_drop_not_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped_full |-> !rsp_is_empty)
      else $error("dropped insert reported with an empty queue");

   // Empty queue reports zero top fields
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_top_name_tag == '0) && (rsp_top_score == '0)
                                    && (rsp_top_roll_number == '0))
      else $error("empty result carries a record");

   // No new result is loaded over one still waiting
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      res_take |-> out_free)
      else $error("result register overwritten while stalled");

endmodule
